### sv/pdat_pkg.sv
// Package for the packet delivery ack tracker: widths, codes and shared types.
// Used by every module of the block; no dependencies.
package pdat_pkg;

  localparam int unsigned InflightDepth = 16;
  localparam int unsigned AckQueueDepth = 8;
  localparam int unsigned SeqBits = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned IfIdxBits = $clog2(InflightDepth);
  localparam int unsigned IfCntBits = $clog2(InflightDepth + 1);
  localparam int unsigned AqIdxBits = $clog2(AckQueueDepth);
  localparam int unsigned AqCntBits = $clog2(AckQueueDepth + 1);
  localparam int unsigned ResCntBits = $clog2(MaxResults + 1);
  localparam int unsigned RangeCntBits = 16;
  localparam logic [RangeCntBits-1:0] CountLimit = 16'hFFFF;
  localparam logic [7:0] SatCount = 8'd255;

  typedef enum logic [1:0] {
    MODE_SEND  = 2'd0,
    MODE_RECV  = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_ACK   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_VERDICT   = 3'd1,
    KIND_RANGE     = 3'd2,
    KIND_DELIVERED = 3'd3,
    KIND_DROPPED   = 3'd4,
    KIND_NOTHING   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] seq_in;
    logic        ack_present;
    logic [15:0] ack_start;
    logic [7:0]  ack_count_minus_one;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] seq_out;
    logic        accepted;
    logic [15:0] range_start;
    logic        range_has_count;
    logic [7:0]  range_count_minus_one;
    logic        last;
    logic [31:0] dispatched_total;
    logic [31:0] acked_total;
    logic [31:0] dropped_total;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input request
    logic rd;     // read queue heads / tail
    logic step;   // perform one action, build a result
    logic drain;  // present the held result as the last one
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;     // the walk goes on after this step
    logic out_busy; // output register still holds a result
  } sts_t;

endpackage

### sv/pdat_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on pdat_pkg for nothing; payload type is a parameter.
interface pdat_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pdat_ctrl.sv
// Controller state machine of the tracker.
// Depends on pdat_pkg.
module pdat_ctrl import pdat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_STEP;
      ST_STEP: begin
        if (!sts_i.out_busy) state_d = sts_i.more ? ST_READ : ST_DRAIN;
      end
      ST_DRAIN: if (!sts_i.out_busy) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_READ:  cmd_o.rd = 1'b1;
      ST_STEP:  cmd_o.step = !sts_i.out_busy;
      ST_DRAIN: cmd_o.drain = !sts_i.out_busy;
      default:  cmd_o = '0;
    endcase
  end
endmodule

### sv/pdat_dp.sv
// Datapath of the tracker: queues, counters, walk state and output register.
// Depends on pdat_pkg.
module pdat_dp import pdat_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);
  logic [SeqBits-1:0] if_mem [InflightDepth];
  logic [SeqBits-1:0] aq_start [AckQueueDepth];
  logic [RangeCntBits-1:0] aq_cnt [AckQueueDepth];

  in_t req_q;
  logic [SeqBits-1:0] next_out_q, next_exp_q;
  logic [IfIdxBits-1:0] if_head_q;
  logic [IfCntBits-1:0] if_used_q;
  logic [AqIdxBits-1:0] aq_head_q;
  logic [AqCntBits-1:0] aq_used_q;
  logic [31:0] disp_q, ack_q, drop_q;
  logic [ResCntBits-1:0] nres_q;
  logic [SeqBits:0] check_q, endv_q;
  logic send_drop_q; // send: dropping phase done
  logic valid_q, valid_d;
  logic held_v_q;
  out_t held_q, out_q, res, held_fin;
  logic [SeqBits-1:0] if_front_q, aq_st_q, tl_st_q;
  logic [RangeCntBits-1:0] aq_ct_q, tl_ct_q;

  logic [IfIdxBits-1:0] if_tail;
  logic [AqIdxBits-1:0] aq_tail, aq_last;
  assign if_tail = if_head_q + if_used_q[IfIdxBits-1:0];
  assign aq_tail = aq_head_q + aq_used_q[AqIdxBits-1:0];
  assign aq_last = aq_tail - 1'b1;

  // registered memory reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      if_front_q <= if_mem[if_head_q];
      aq_st_q <= aq_start[aq_head_q];
      aq_ct_q <= aq_cnt[aq_head_q];
      tl_st_q <= aq_start[aq_last];
      tl_ct_q <= aq_cnt[aq_last];
    end
  end

  // step decision
  logic if_full, if_push, if_pop, aq_push, aq_ext, aq_pop;
  logic [31:0] disp_d, ack_d, drop_d;
  logic [SeqBits:0] check_d;
  logic any, fin;
  logic [SeqBits-1:0] seq_res;
  kind_e kind;
  logic acc;
  logic [SeqBits:0] tail_end;
  logic s_ge;
  logic [7:0] cm1;
  logic [ResCntBits-1:0] nres_n;
  logic emit_mid, capture;

  assign if_full = (if_used_q == IfCntBits'(InflightDepth));
  assign tail_end = {1'b0, tl_st_q} + {1'b0, tl_ct_q};
  assign s_ge = req_q.seq_in >= next_exp_q;
  assign nres_n = nres_q + 1'b1;

  always_comb begin
    if_push = 1'b0; if_pop = 1'b0; aq_push = 1'b0; aq_ext = 1'b0; aq_pop = 1'b0;
    disp_d = disp_q; ack_d = ack_q; drop_d = drop_q;
    check_d = check_q;
    any = 1'b0; fin = 1'b1; seq_res = '0; kind = KIND_NOTHING; acc = 1'b0;
    cm1 = '0;
    case (mode_e'(req_q.mode))
      MODE_SEND: begin
        any = 1'b1;
        if (if_full && !send_drop_q) begin
          if_pop = 1'b1; drop_d = drop_q + 32'd1; kind = KIND_DROPPED;
          seq_res = if_front_q; fin = 1'b0;
        end else begin
          if_push = 1'b1; disp_d = disp_q + 32'd1; kind = KIND_ASSIGNED;
          seq_res = next_out_q;
        end
      end
      MODE_RECV: begin
        any = 1'b1; kind = KIND_VERDICT;
        if (s_ge) begin
          if (aq_used_q != '0 && {1'b0, req_q.seq_in} == tail_end &&
              tl_ct_q < CountLimit) begin
            aq_ext = 1'b1; acc = 1'b1;
          end else if (aq_used_q < AqCntBits'(AckQueueDepth)) begin
            aq_push = 1'b1; acc = 1'b1;
          end
        end
      end
      MODE_FLUSH: begin
        if (aq_used_q != '0 && nres_q < ResCntBits'(MaxResults)) begin
          any = 1'b1; aq_pop = 1'b1; kind = KIND_RANGE;
          if (aq_ct_q > RangeCntBits'(1)) begin
            cm1 = (aq_ct_q > RangeCntBits'(256)) ? SatCount :
                  8'(aq_ct_q - RangeCntBits'(1));
          end
          fin = !(aq_used_q > AqCntBits'(1) && nres_n < ResCntBits'(MaxResults));
        end
      end
      default: begin
        // ack walk: a newer front just moves check and costs no result
        if (req_q.ack_present && check_q < endv_q && if_used_q != '0 &&
            nres_q < ResCntBits'(MaxResults)) begin
          fin = 1'b0;
          if ({1'b0, if_front_q} == check_q) begin
            any = 1'b1; if_pop = 1'b1; ack_d = ack_q + 32'd1;
            kind = KIND_DELIVERED; seq_res = if_front_q; check_d = check_q + 1'b1;
          end else if ({1'b0, if_front_q} < check_q) begin
            any = 1'b1; if_pop = 1'b1; drop_d = drop_q + 32'd1;
            kind = KIND_DROPPED; seq_res = if_front_q;
          end else begin
            check_d = {1'b0, if_front_q};
          end
        end
      end
    endcase
  end

  // result building: counters after the event
  always_comb begin
    res = '0;
    res.kind = kind;
    res.seq_out = seq_res;
    res.accepted = acc;
    res.range_start = aq_pop ? aq_st_q : '0;
    res.range_has_count = aq_pop && (aq_ct_q > RangeCntBits'(1));
    res.range_count_minus_one = cm1;
    res.dispatched_total = disp_d;
    res.acked_total = ack_d;
    res.dropped_total = drop_d;
  end

  always_comb begin
    held_fin = held_q;
    held_fin.last = 1'b1;
  end

  // the last flag is only known once the walk stops, so one result is held back
  assign emit_mid = cmd_i.step && any && held_v_q;
  assign capture = cmd_i.step && (any || (fin && !held_v_q));
  assign valid_d = emit_mid || cmd_i.drain || (valid_q && !out_ready_i);

  assign sts_o.more = !fin;
  assign sts_o.out_busy = valid_q && !out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_out_q <= SeqBits'(1); next_exp_q <= '0;
      if_head_q <= '0; if_used_q <= '0; aq_head_q <= '0; aq_used_q <= '0;
      disp_q <= '0; ack_q <= '0; drop_q <= '0;
      nres_q <= '0; send_drop_q <= 1'b0;
      valid_q <= 1'b0; held_v_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (capture) held_v_q <= 1'b1;
      else if (cmd_i.drain) held_v_q <= 1'b0;
      if (cmd_i.load) begin
        nres_q <= '0; send_drop_q <= 1'b0;
      end else if (cmd_i.step) begin
        disp_q <= disp_d; ack_q <= ack_d; drop_q <= drop_d;
        if (if_pop) if_head_q <= if_head_q + 1'b1;
        if_used_q <= if_used_q + IfCntBits'(if_push) - IfCntBits'(if_pop);
        if (if_push) next_out_q <= next_out_q + 1'b1;
        if (aq_pop) aq_head_q <= aq_head_q + 1'b1;
        aq_used_q <= aq_used_q + AqCntBits'(aq_push) - AqCntBits'(aq_pop);
        if (acc) next_exp_q <= req_q.seq_in + 1'b1;
        if (if_pop && mode_e'(req_q.mode) == MODE_SEND) send_drop_q <= 1'b1;
        if (any) nres_q <= nres_n;
      end
    end
  end

  // request capture, result registers and memory writes
  always_ff @(posedge clk_i) begin
    if (capture) held_q <= res;
    if (emit_mid) out_q <= held_q;
    else if (cmd_i.drain) out_q <= held_fin;
    if (cmd_i.load) begin
      req_q <= in_i;
      check_q <= {1'b0, in_i.ack_start};
      endv_q <= {1'b0, in_i.ack_start} + {9'd0, in_i.ack_count_minus_one} + 1'b1;
    end else if (cmd_i.step) begin
      check_q <= check_d;
      if (if_push) if_mem[if_tail] <= next_out_q;
      if (aq_push) begin
        aq_start[aq_tail] <= req_q.seq_in;
        aq_cnt[aq_tail] <= RangeCntBits'(1);
      end
      if (aq_ext) aq_cnt[aq_last] <= tl_ct_q + 1'b1;
    end
  end
endmodule

### sv/packet_delivery_ack_tracker_top.sv
// Channel   | dir | payload
// in_ch     | in  | mode, seq_in, ack_present, ack_start, ack_count_minus_one
// out_ch    | out | kind, seq_out, accepted, range fields, last, totals
// Each step passes through a read state and a step state; a result is held
// back until the next result is built, the final one leaves in the drain state.
// A 16-result ack walk with compare-point moves needs up to 33 steps.
// Reset clears all pointers and counters; queue contents stay undefined.
// A stalled output holds the controller in its step or drain state.
// Depends on pdat_pkg, pdat_if, pdat_ctrl, pdat_dp.
module packet_delivery_ack_tracker_top import pdat_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  pdat_if.sink in_ch,
  pdat_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;

  pdat_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_ready_o(in_ch.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  pdat_dp u_dp (
    .clk_i, .rst_ni, .in_i(in_ch.data), .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready), .out_o(out_ch.data)
  );
endmodule

### sv/pdat_checker.sv
// Port-level checker for the tracker, bound to the top level.
// Depends on pdat_pkg.
module pdat_checker import pdat_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("hold");
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.kind <= KIND_NOTHING) else $error("kind");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready) else $error("busy");
endmodule

bind packet_delivery_ack_tracker_top pdat_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

### bench/tb_packet_delivery_ack_tracker_top.sv
// Testbench for packet_delivery_ack_tracker_top: random and directed requests
// through the valid/ready channels, checked against a behavioral tracker model.
// Depends on pdat_pkg, pdat_if and the block's RTL.
`timescale 1ns / 100ps

module tb_packet_delivery_ack_tracker_top;
  import pdat_pkg::*;

  logic clk_i;
  logic rst_ni;

  pdat_if #(.T(in_t))  in_ch ();
  pdat_if #(.T(out_t)) out_ch ();

  packet_delivery_ack_tracker_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // tracker model state
  logic [15:0] m_next_out;
  logic [15:0] m_next_exp;
  logic [15:0] m_inflight [InflightDepth];
  int unsigned m_if_head, m_if_used;
  logic [15:0] m_rng_start [AckQueueDepth];
  logic [16:0] m_rng_count [AckQueueDepth];
  int unsigned m_aq_head, m_aq_used;
  logic [31:0] m_dispatched, m_acked, m_dropped;

  in_t  request_q [$];
  out_t expected_q [$];
  int   errors;
  int   results_seen;
  bit   quiet_in, quiet_out;

  function automatic void push_result(kind_e k, logic [15:0] s, logic acc,
                                      logic [15:0] rs, logic [16:0] rc);
    out_t r;
    r = '0;
    r.kind = k;
    r.seq_out = s;
    r.accepted = acc;
    r.range_start = rs;
    if (rc > 1) begin
      r.range_has_count = 1'b1;
      r.range_count_minus_one = (rc - 1 > 255) ? SatCount : 8'(rc - 1);
    end
    r.dispatched_total = m_dispatched;
    r.acked_total = m_acked;
    r.dropped_total = m_dropped;
    expected_q.push_back(r);
  endfunction

  function automatic logic [15:0] pop_inflight();
    logic [15:0] s;
    s = m_inflight[m_if_head];
    m_if_head = (m_if_head + 1) % InflightDepth;
    m_if_used--;
    return s;
  endfunction

  function automatic void predict_tracker(in_t rq);
    int n;
    int unsigned bi;
    logic [15:0] s;
    logic [31:0] check, endv;
    bit acc, ext;
    n = 0;
    case (mode_e'(rq.mode))
      MODE_SEND: begin
        s = m_next_out;
        if (m_if_used >= InflightDepth) begin
          m_dropped++;
          push_result(KIND_DROPPED, pop_inflight(), 0, 0, 0);
          n++;
        end
        m_next_out = s + 16'd1;
        m_dispatched++;
        m_inflight[(m_if_head + m_if_used) % InflightDepth] = s;
        m_if_used++;
        push_result(KIND_ASSIGNED, s, 0, 0, 0);
        n++;
      end
      MODE_RECV: begin
        s = rq.seq_in;
        acc = 0;
        ext = 0;
        if (s >= m_next_exp) begin
          if (m_aq_used > 0) begin
            bi = (m_aq_head + m_aq_used - 1) % AckQueueDepth;
            if (32'(s) == 32'(m_rng_start[bi]) + 32'(m_rng_count[bi]) &&
                m_rng_count[bi] < 17'd65535) begin
              m_rng_count[bi]++;
              ext = 1;
            end
          end
          if (ext) acc = 1;
          else if (m_aq_used < AckQueueDepth) begin
            bi = (m_aq_head + m_aq_used) % AckQueueDepth;
            m_rng_start[bi] = s;
            m_rng_count[bi] = 1;
            m_aq_used++;
            acc = 1;
          end
          if (acc) m_next_exp = s + 16'd1;
        end
        push_result(KIND_VERDICT, 0, acc, 0, 0);
        n++;
      end
      MODE_FLUSH: begin
        while (m_aq_used > 0 && n < MaxResults) begin
          bi = m_aq_head;
          m_aq_head = (m_aq_head + 1) % AckQueueDepth;
          m_aq_used--;
          push_result(KIND_RANGE, 0, 0, m_rng_start[bi], m_rng_count[bi]);
          n++;
        end
      end
      default: begin
        if (rq.ack_present) begin
          check = 32'(rq.ack_start);
          endv = check + 32'(rq.ack_count_minus_one) + 32'd1;
          while (check < endv && m_if_used > 0 && n < MaxResults) begin
            s = m_inflight[m_if_head];
            if (32'(s) == check) begin
              void'(pop_inflight());
              m_acked++;
              push_result(KIND_DELIVERED, s, 0, 0, 0);
              n++;
              check++;
            end else if (32'(s) < check) begin
              void'(pop_inflight());
              m_dropped++;
              push_result(KIND_DROPPED, s, 0, 0, 0);
              n++;
            end else begin
              check = 32'(s);
            end
          end
        end
      end
    endcase
    if (n == 0) push_result(KIND_NOTHING, 0, 0, 0, 0);
    expected_q[$].last = 1'b1;
  endfunction

  function automatic in_t make_request(mode_e md, logic [15:0] sq, logic ap,
                                       logic [15:0] as, logic [7:0] cm);
    in_t rq;
    rq.mode = md;
    rq.seq_in = sq;
    rq.ack_present = ap;
    rq.ack_start = as;
    rq.ack_count_minus_one = cm;
    return rq;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_tracker(in_ch.data);
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() > 0 && (quiet_in || $urandom_range(99) >= 32)) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= request_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_r;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= quiet_out || $urandom_range(99) >= 32;
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $realtime,
                   out_ch.data);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.data !== exp_r) begin
            $display("%0t: mismatch, expected %p, actual %p", $realtime, exp_r,
                     out_ch.data);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    in_t rq;
    int unsigned base;
    errors = 0;
    results_seen = 0;
    quiet_in = 1;
    quiet_out = 1;
    m_next_out = 16'd1;
    m_next_exp = '0;
    m_if_head = 0;
    m_if_used = 0;
    m_aq_head = 0;
    m_aq_used = 0;
    m_dispatched = '0;
    m_acked = '0;
    m_dropped = '0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queues, overflow, ranges, saturation, old receive
    request_q.push_back(make_request(MODE_FLUSH, 0, 0, 0, 0));
    request_q.push_back(make_request(MODE_ACK, 0, 0, 0, 0));
    request_q.push_back(make_request(MODE_ACK, 0, 1, 16'hFFFF, 8'hFF));
    for (int i = 0; i < 17; i++) request_q.push_back(make_request(MODE_SEND, 0, 0, 0, 0));
    request_q.push_back(make_request(MODE_ACK, 0, 1, 16'd3, 8'd2));
    request_q.push_back(make_request(MODE_ACK, 0, 1, 16'd0, 8'hFF));
    request_q.push_back(make_request(MODE_RECV, 16'd0, 0, 0, 0));
    request_q.push_back(make_request(MODE_RECV, 16'd0, 0, 0, 0));
    request_q.push_back(make_request(MODE_FLUSH, 0, 0, 0, 0));

    // long adjacent run saturates the emitted count
    for (int i = 1; i < 258; i++)
      request_q.push_back(make_request(MODE_RECV, 16'(i), 0, 0, 0));
    // sparse receives fill the ack queue and hit the reject path
    for (int i = 0; i < 10; i++)
      request_q.push_back(make_request(MODE_RECV, 16'(400 + 3 * i), 0, 0, 0));
    request_q.push_back(make_request(MODE_FLUSH, 0, 0, 0, 0));
    request_q.push_back(make_request(MODE_RECV, 16'hFFFF, 0, 0, 0));
    request_q.push_back(make_request(MODE_RECV, 16'h0005, 0, 0, 0));
    request_q.push_back(make_request(MODE_FLUSH, 0, 0, 0, 0));

    // random: mostly realistic send/ack traffic, some noise
    for (int i = 0; i < 60; i++) begin
      if (i == 8) begin
        quiet_in = 0;
        quiet_out = 0;
      end
      case ($urandom_range(9))
        0, 1, 2, 3: rq = make_request(MODE_SEND, 16'($urandom), 1'($urandom),
                                      16'($urandom), 8'($urandom));
        4, 5: rq = make_request(MODE_RECV, $urandom_range(3) == 0 ? 16'($urandom) :
                                16'(i * 2 + $urandom_range(3)), 1'($urandom),
                                16'($urandom), 8'($urandom));
        6: rq = make_request(MODE_FLUSH, 16'($urandom), 1'($urandom), 16'($urandom),
                             8'($urandom));
        7, 8: begin
          base = (m_next_out > 20) ? m_next_out - $urandom_range(20) : 0;
          rq = make_request(MODE_ACK, 16'($urandom), $urandom_range(7) != 0, 16'(base),
                            8'($urandom_range(12)));
        end
        default: rq = make_request(MODE_ACK, 16'($urandom), 1'($urandom), 16'($urandom),
                                   8'($urandom));
      endcase
      request_q.push_back(rq);
      while (request_q.size() > 4) @(posedge clk_i);
    end

    while (request_q.size() > 0 || in_ch.valid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Ran send, receive, flush and ack walks with queue overflow and saturation;");
    $display("%0d results checked, %0d mismatches.", results_seen, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_packet_delivery_ack_tracker_top passed");
    end else begin
      $display("tb_packet_delivery_ack_tracker_top failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_packet_delivery_ack_tracker_top failed");
    $finish;
  end

endmodule
